@@ sv/nfres_pkg.sv @@
// Shared types, constants and sector map functions of the range erase sequencer.
`default_nettype none
package nfres_pkg;

	// Chip geometry
	localparam int unsigned CHIP_BYTES        = 4194304;
	localparam int unsigned SECTOR_UNIT_SHIFT = 8;
	localparam int unsigned SECTOR_COUNT      = 71;
	localparam int unsigned ADDR_W            = 22;
	localparam int unsigned LEN_W             = 23;
	localparam int unsigned SECT_W            = 7;
	localparam int unsigned UNIT_W            = ADDR_W - SECTOR_UNIT_SHIFT;

	// Boot block layout in 256-byte units
	localparam logic [UNIT_W-1:0] BOOT_BASE_UNIT = UNIT_W'(14'h3F00);
	localparam logic [SECT_W-1:0] BIG_SECTORS    = SECT_W'(63);
	localparam logic [SECT_W-1:0] TOP_SECTOR     = SECT_W'(SECTOR_COUNT - 1);

	// Operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_POLL  = 1'b1;

	// Status byte bits
	localparam int unsigned DQ7 = 7;
	localparam int unsigned DQ5 = 5;

	// Result FIFO depth default (holds at least one two-result burst)
	localparam int unsigned RSP_FIFO_DEPTH = 4;

	typedef enum logic [2:0] {
		KIND_SECTOR   = 3'd0,
		KIND_CHIP     = 3'd1,
		KIND_RESET    = 3'd2,
		KIND_DONE_OK  = 3'd3,
		KIND_DONE_ERR = 3'd4,
		KIND_RANGE    = 3'd5,
		KIND_BUSY     = 3'd6
	} kind_t;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] start_address;
		logic [LEN_W-1:0]  byte_count;
		logic [7:0]        status_read;
		logic [7:0]        status_reread;
	} req_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] sector_address;
		logic              last;
	} rsp_t;

	// Push request from the decode stage to the result FIFO
	typedef struct packed {
		logic [1:0] count;
		rsp_t       first;
		rsp_t       second;
	} push_t;

	// Sector index that holds a byte address
	function automatic logic [SECT_W-1:0] sector_of(input logic [ADDR_W-1:0] a);
		logic [UNIT_W-1:0] unit;
		unit = UNIT_W'(a >> SECTOR_UNIT_SHIFT);
		if (unit < BOOT_BASE_UNIT)
			return SECT_W'(unit >> 8);
		return BIG_SECTORS + SECT_W'((unit - BOOT_BASE_UNIT) >> 5);
	endfunction

	// Byte address of the first byte of a sector
	function automatic logic [ADDR_W-1:0] sector_base(input logic [SECT_W-1:0] s);
		logic [UNIT_W-1:0] unit;
		logic [UNIT_W-1:0] off;
		off = UNIT_W'(s - BIG_SECTORS);
		if (s < BIG_SECTORS)
			unit = UNIT_W'(s) << 8;
		else
			unit = BOOT_BASE_UNIT + (off << 5);
		return ADDR_W'(unit) << SECTOR_UNIT_SHIFT;
	endfunction

endpackage
`default_nettype wire

@@ sv/nfres_if.sv @@
// Valid/ready channel interfaces for erase requests and results.
`default_nettype none
interface nfres_req_if;
	logic            valid;
	logic            ready;
	nfres_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface nfres_rsp_if;
	logic            valid;
	logic            ready;
	nfres_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/nfres_rsp_fifo.sv @@
// Result FIFO: takes up to two results per cycle, hands out one per transaction.
`default_nettype none
module nfres_rsp_fifo #(
	parameter int unsigned DEPTH = nfres_pkg::RSP_FIFO_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire nfres_pkg::push_t push,
	output logic                 room2,
	nfres_rsp_if.source          rsp
);
	import nfres_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rsp_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_p1;
	logic [PTR_W-1:0] wr_ptr_p2;
	logic [PTR_W-1:0] rd_ptr_p1;
	logic             pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);
	assign rd_ptr_p1 = ptr_inc(rd_ptr_q);
	assign pop       = rsp.valid && rsp.ready;
	assign room2     = count_q <= CNT_W'(DEPTH - 2);
	assign rsp.valid = count_q != '0;
	assign rsp.payload = mem_q[rd_ptr_q];

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[wr_ptr_p1] <= push.second;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push.count)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= wr_ptr_p2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop)
				rd_ptr_q <= rd_ptr_p1;
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

@@ sv/nor_flash_range_erase_sequencer.sv @@
// Top level of the NOR flash range erase sequencer.
// Takes one request transaction per cycle: a start (address, byte count) or a poll
// (two status bytes). A request is registered, decoded against the sector map, and
// its results (none, one, or a reset/error pair) land in a small result FIFO, which
// registers them before they appear. The decode stage moves on only while the FIFO
// has room for two results; with the result side taking one transaction per cycle
// the block takes one request per cycle while that room lasts. A start while an
// erase runs returns busy; a chip-wide range is issued as a single chip erase, any
// other range as one sector erase per DQ7 completion.
`default_nettype none
module nor_flash_range_erase_sequencer #(
	parameter int unsigned RSP_DEPTH = nfres_pkg::RSP_FIFO_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nfres_req_if.sink   req,
	nfres_rsp_if.source rsp
);
	import nfres_pkg::*;

	req_t              req_s1;
	logic              valid_s1;
	logic              busy_q;
	logic              whole_chip_q;
	logic [SECT_W-1:0] current_sector_q;
	logic [SECT_W-1:0] final_sector_q;

	logic              busy_d;
	logic              whole_chip_d;
	logic [SECT_W-1:0] current_sector_d;
	logic [SECT_W-1:0] final_sector_d;
	logic              room2;
	logic              advance;
	push_t             push;
	logic [ADDR_W+1:0] range_end;
	logic [ADDR_W+1:0] end_addr;
	logic [SECT_W-1:0] first_sec;
	logic [SECT_W-1:0] last_sec;
	logic [SECT_W-1:0] next_sec;
	logic              done_hit;

	assign advance   = valid_s1 && room2;
	assign req.ready = !valid_s1 || room2;

	// Hold the request in the input stage
	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			req_s1 <= req.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	// Range and sector lookup
	assign range_end = (ADDR_W+2)'(req_s1.start_address) + (ADDR_W+2)'(req_s1.byte_count);
	assign end_addr  = range_end - (ADDR_W+2)'(1);
	assign first_sec = sector_of(req_s1.start_address);
	assign last_sec  = sector_of(end_addr[ADDR_W-1:0]);
	assign next_sec  = current_sector_q + SECT_W'(1);
	assign done_hit  = req_s1.status_read[DQ7] ||
		(req_s1.status_read[DQ5] && req_s1.status_reread[DQ7]);

	// Decode one request into results and the next sequencer state
	always_comb begin
		busy_d           = busy_q;
		whole_chip_d     = whole_chip_q;
		current_sector_d = current_sector_q;
		final_sector_d   = final_sector_q;
		push.count       = 2'd0;
		push.first       = '{kind: KIND_DONE_OK, sector_address: '0, last: 1'b1};
		push.second      = '{kind: KIND_DONE_ERR, sector_address: '0, last: 1'b1};
		if (advance) begin
			if (req_s1.operation == OP_START) begin
				push.count = 2'd1;
				if (busy_q) begin
					push.first.kind = KIND_BUSY;
				end else if (req_s1.byte_count == '0) begin
					push.first.kind = KIND_DONE_OK;
				end else if (range_end > (ADDR_W+2)'(CHIP_BYTES)) begin
					push.first.kind = KIND_RANGE;
				end else begin
					busy_d           = 1'b1;
					current_sector_d = first_sec;
					final_sector_d   = last_sec;
					if (first_sec == '0 && last_sec == TOP_SECTOR) begin
						whole_chip_d    = 1'b1;
						push.first.kind = KIND_CHIP;
					end else begin
						whole_chip_d              = 1'b0;
						push.first.kind           = KIND_SECTOR;
						push.first.sector_address = sector_base(first_sec);
					end
				end
			end else if (busy_q) begin
				if (done_hit) begin
					push.count = 2'd1;
					if (whole_chip_q) begin
						busy_d       = 1'b0;
						whole_chip_d = 1'b0;
					end else begin
						current_sector_d = next_sec;
						if (next_sec <= final_sector_q &&
						    next_sec < SECT_W'(SECTOR_COUNT)) begin
							push.first.kind           = KIND_SECTOR;
							push.first.sector_address = sector_base(next_sec);
						end else begin
							busy_d = 1'b0;
						end
					end
				end else if (req_s1.status_read[DQ5]) begin
					busy_d          = 1'b0;
					whole_chip_d    = 1'b0;
					push.count      = 2'd2;
					push.first.kind = KIND_RESET;
					push.first.last = 1'b0;
				end
			end
		end
	end

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q           <= 1'b0;
			whole_chip_q     <= 1'b0;
			current_sector_q <= '0;
			final_sector_q   <= '0;
		end else begin
			busy_q           <= busy_d;
			whole_chip_q     <= whole_chip_d;
			current_sector_q <= current_sector_d;
			final_sector_q   <= final_sector_d;
		end
	end

	nfres_rsp_fifo #(
		.DEPTH(RSP_DEPTH)
	) u_rsp_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room2 (room2),
		.rsp   (rsp)
	);

	// A chip erase only runs while the sequencer is busy
	a_chip_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		whole_chip_q |-> busy_q)
		else $error("chip erase flag set while idle");

	// A running sector erase stays inside the range and the sector map
	a_sector_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (current_sector_q <= final_sector_q &&
		            final_sector_q < SECT_W'(SECTOR_COUNT)))
		else $error("current sector outside planned range");

	// A reset result is always followed by the error result
	a_reset_then_err: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && rsp.payload.kind == KIND_RESET) |=>
		(rsp.valid && rsp.payload.kind == KIND_DONE_ERR && rsp.payload.last))
		else $error("reset result not followed by error result");

endmodule
`default_nettype wire
